// ===== rtl/olist_pkg.sv =====
package olist_pkg;

  localparam int DATA_W           = 32;
  localparam int MODE_W           = 3;
  localparam int STATUS_W         = 2;
  localparam int COUNT_W          = 6;
  localparam int DEFAULT_CAPACITY = 32;

  // Codes six and seven carry no operation; they fall to the default arm.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_REVERSE    = 3'd3,
    MODE_INSERT     = 3'd4,
    MODE_DUMP       = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

endpackage

// ===== rtl/olist_if.sv =====
interface olist_item_if import olist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, mode, item_value, input ready);
  modport sink   (input valid, mode, item_value, output ready);
endinterface

interface olist_result_if import olist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] entry_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       entry_count;
  logic                     last;

  modport source (output valid, entry_value, status, entry_count, last, input ready);
  modport sink   (input valid, entry_value, status, entry_count, last, output ready);
endinterface

// ===== rtl/ordered_list_engine.sv =====
// Bounded double-ended list of signed 32-bit values with ordered insert.
//
// Channels: item (sink) carries mode and item_value; result (source) carries
// entry_value, status, entry_count and last. A word moves on valid && ready.
// Every mode yields one result word with last set, except dump, which streams
// every entry from head to tail (one word for an empty list, status empty).
//
// Push, pop, reverse and unused modes pass the update state, then the respond
// state, which raises result valid. Ordered insert makes one forward pass, one
// store read a cycle, finding the insert point and shifting the tail by one
// slot on the way, then responds; the next item is taken only after that.
// Dump sends its first word after the update state, then one word a cycle
// while the receiver takes them.
//
// One item is worked at a time; item.ready is high only between items. The
// result register lets the next item be accepted while a word still waits.
// A stalled receiver holds the result word and freezes a dump in progress.
//
// Reset clears the head pointer, the count and the direction flag; the entry
// store itself is not cleared and needs no clearing pass.
module ordered_list_engine import olist_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic           clk,
  input  logic           rst,
  olist_item_if.sink     item,
  olist_result_if.source result
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS,
    S_DUMP,
    S_RESP
  } state_t;

  // Physical slot of logical position pos, counted from the head.
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] pos,
                                               input logic rev);
    logic [SUM_W-1:0] sum;
    if (rev) begin
      sum = {1'b0, base} + SUM_W'(CAPACITY) - SUM_W'(pos);
    end else begin
      sum = {1'b0, base} + SUM_W'(pos);
    end
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_up(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(CAPACITY - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_down(input logic [IDX_W-1:0] s);
    return (s == '0) ? IDX_W'(CAPACITY - 1) : s - 1'b1;
  endfunction

  // List state and sequencer registers
  state_t                   state, state_next;
  logic [IDX_W-1:0]         start, start_next;
  logic [CNT_W-1:0]         fill, fill_next;
  logic                     rev, rev_next;
  mode_t                    cur_mode, cur_mode_next;
  logic signed [DATA_W-1:0] cur_value, cur_value_next;
  status_t                  resp, resp_next;
  logic [CNT_W-1:0]         idx, idx_next;
  logic [IDX_W-1:0]         data_slot, data_slot_next;
  logic signed [DATA_W-1:0] prev, prev_next;
  logic                     have_prev, have_prev_next;
  logic signed [DATA_W-1:0] carry, carry_next;
  logic                     shifting, shifting_next;

  // Result register
  logic                     out_valid, out_valid_next;
  logic signed [DATA_W-1:0] out_value, out_value_next;
  status_t                  out_status, out_status_next;
  logic [CNT_W-1:0]         out_count, out_count_next;
  logic                     out_last, out_last_next;

  // Entry store ports
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  logic             full;
  logic             out_free;
  logic             at_end;
  logic [IDX_W-1:0] step_slot;
  logic [IDX_W-1:0] front_slot;

  olist_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign full       = (fill == CNT_W'(CAPACITY));
  assign out_free   = !out_valid || result.ready;
  assign at_end     = (idx == fill);
  // Next slot toward the tail, and the slot ahead of the head
  assign step_slot  = rev ? slot_down(data_slot) : slot_up(data_slot);
  assign front_slot = rev ? slot_up(start) : slot_down(start);

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.entry_value = out_value;
  assign result.status      = out_status;
  assign result.entry_count = COUNT_W'(out_count);
  assign result.last        = out_last;

  always_comb begin
    state_next      = state;
    start_next      = start;
    fill_next       = fill;
    rev_next        = rev;
    cur_mode_next   = cur_mode;
    cur_value_next  = cur_value;
    resp_next       = resp;
    idx_next        = idx;
    data_slot_next  = data_slot;
    prev_next       = prev;
    have_prev_next  = have_prev;
    carry_next      = carry;
    shifting_next   = shifting;
    out_valid_next  = out_valid && !result.ready;
    out_value_next  = out_value;
    out_status_next = out_status;
    out_count_next  = out_count;
    out_last_next   = out_last;
    wr_en           = 1'b0;
    wr_addr         = data_slot;
    wr_data         = carry;
    rd_en           = 1'b0;
    rd_addr         = step_slot;

    case (state)
      S_IDLE: begin
        if (item.valid) begin
          cur_mode_next  = mode_t'(item.mode);
          cur_value_next = item.item_value;
          state_next     = S_EXEC;
        end
      end

      S_EXEC: begin
        resp_next  = ST_OK;
        state_next = S_RESP;
        case (cur_mode)
          MODE_PUSH_FRONT: begin
            if (full) begin
              resp_next = ST_FULL;
            end else begin
              start_next = front_slot;
              wr_en      = 1'b1;
              wr_addr    = front_slot;
              wr_data    = cur_value;
              fill_next  = fill + 1'b1;
            end
          end
          MODE_PUSH_BACK: begin
            if (full) begin
              resp_next = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = slot_at(start, fill, rev);
              wr_data   = cur_value;
              fill_next = fill + 1'b1;
            end
          end
          MODE_POP_FRONT: begin
            if (fill == '0) begin
              resp_next = ST_EMPTY;
            end else begin
              start_next = rev ? slot_down(start) : slot_up(start);
              fill_next  = fill - 1'b1;
            end
          end
          MODE_REVERSE: begin
            // The tail becomes the head and the walk direction flips.
            if (fill > CNT_W'(1)) begin
              start_next = slot_at(start, fill - 1'b1, rev);
              rev_next   = !rev;
            end
          end
          MODE_INSERT: begin
            rd_en          = 1'b1;
            rd_addr        = start;
            data_slot_next = start;
            idx_next       = '0;
            have_prev_next = 1'b0;
            shifting_next  = 1'b0;
            state_next     = S_INS;
          end
          MODE_DUMP: begin
            if (fill == '0) begin
              resp_next = ST_EMPTY;
            end else begin
              rd_en          = 1'b1;
              rd_addr        = start;
              data_slot_next = start;
              idx_next       = '0;
              state_next     = S_DUMP;
            end
          end
          default: begin
            resp_next = ST_OK;
          end
        endcase
      end

      S_INS: begin
        // rd_data holds the entry at logical position idx unless at_end.
        if (!shifting && !at_end && (rd_data <= cur_value)) begin
          // Walk past entries not greater than the new value.
          prev_next      = rd_data;
          have_prev_next = 1'b1;
          idx_next       = idx + 1'b1;
          data_slot_next = step_slot;
          rd_en          = 1'b1;
        end else if (!shifting) begin
          // Insert point found: drop a duplicate, refuse on full.
          if (have_prev && (prev == cur_value)) begin
            resp_next  = ST_DUP;
            state_next = S_RESP;
          end else if (full) begin
            resp_next  = ST_FULL;
            state_next = S_RESP;
          end else begin
            wr_en   = 1'b1;
            wr_data = cur_value;
            if (at_end) begin
              fill_next  = fill + 1'b1;
              resp_next  = ST_OK;
              state_next = S_RESP;
            end else begin
              carry_next     = rd_data;
              shifting_next  = 1'b1;
              idx_next       = idx + 1'b1;
              data_slot_next = step_slot;
              rd_en          = 1'b1;
            end
          end
        end else begin
          // Shift: write the carried entry one slot down, carry the old one.
          wr_en   = 1'b1;
          wr_data = carry;
          if (at_end) begin
            fill_next  = fill + 1'b1;
            resp_next  = ST_OK;
            state_next = S_RESP;
          end else begin
            carry_next     = rd_data;
            idx_next       = idx + 1'b1;
            data_slot_next = step_slot;
            rd_en          = 1'b1;
          end
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_value_next  = rd_data;
          out_status_next = ST_OK;
          out_count_next  = fill;
          out_last_next   = (idx + 1'b1 == fill);
          if (idx + 1'b1 == fill) begin
            state_next = S_IDLE;
          end else begin
            idx_next       = idx + 1'b1;
            data_slot_next = step_slot;
            rd_en          = 1'b1;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_value_next  = '0;
          out_status_next = resp;
          out_count_next  = fill;
          out_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start     <= '0;
      fill      <= '0;
      rev       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      start     <= start_next;
      fill      <= fill_next;
      rev       <= rev_next;
      out_valid <= out_valid_next;
    end
    cur_mode   <= cur_mode_next;
    cur_value  <= cur_value_next;
    resp       <= resp_next;
    idx        <= idx_next;
    data_slot  <= data_slot_next;
    prev       <= prev_next;
    have_prev  <= have_prev_next;
    carry      <= carry_next;
    shifting   <= shifting_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
    out_count  <= out_count_next;
    out_last   <= out_last_next;
  end

`ifndef SYNTHESIS
  // The count never runs past the store depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // The shift pass writes behind its read pointer: never the same slot at once.
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("store read and write hit the same slot");

  // A taken word without last leaves the dump still running.
  a_dump_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.ready && !out_last) |-> (state == S_DUMP))
    else $error("non-final word taken outside a dump");

  // Dump words before the last carry status ok.
  a_dump_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_status == ST_OK))
    else $error("non-final word with non-ok status");

  // The list does not change while waiting for an item.
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> ($stable(fill) && $stable(start) && $stable(rev)))
    else $error("list state changed while idle");
`endif

endmodule

// ===== rtl/olist_store.sv =====
module olist_store import olist_pkg::*; #(
  parameter int DEPTH  = DEFAULT_CAPACITY,
  parameter int ADDR_W = $clog2(DEFAULT_CAPACITY)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
